@@ rtl/core/swt_pkg.sv @@
package swt_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_REG_WRITE  = 3'd0,
    REQ_TIMER_TICK = 3'd1,
    REQ_QUARTER    = 3'd2,
    REQ_HALF       = 3'd3,
    REQ_ENABLE     = 3'd4
  } swt_req_t;

  // Channel register indexes
  localparam logic [1:0] REG_CTRL      = 2'd0;
  localparam logic [1:0] REG_SWEEP     = 2'd1;
  localparam logic [1:0] REG_PERIOD_LO = 2'd2;
  localparam logic [1:0] REG_PERIOD_HI = 2'd3;

  localparam int unsigned PERIOD_W = 11;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD = 11'd8;
  localparam logic [3:0] ENV_MAX = 4'd15;
  localparam logic NEGATE_RESET = 1'b1;

  localparam logic [7:0] DUTY_PATTERNS [4] = '{8'h01, 8'h03, 8'h0F, 8'hFC};

  localparam logic [7:0] LENGTH_LOADS [32] = '{
    8'd10,  8'd254, 8'd20,  8'd2,  8'd40,  8'd4,  8'd80,  8'd6,
    8'd160, 8'd8,   8'd60,  8'd10, 8'd14,  8'd12, 8'd26,  8'd14,
    8'd12,  8'd16,  8'd24,  8'd18, 8'd48,  8'd20, 8'd96,  8'd22,
    8'd192, 8'd24,  8'd72,  8'd26, 8'd16,  8'd28, 8'd32,  8'd30
  };

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] reg_index;
    logic [7:0] write_data;
  } swt_item_t;

  typedef struct packed {
    logic [1:0]          duty_select;
    logic                halt_or_loop;
    logic                fixed_volume_flag;
    logic [3:0]          volume_value;
    logic                sweep_on;
    logic [2:0]          sweep_reload_period;
    logic                sweep_down;
    logic [2:0]          sweep_shift_amount;
    logic                sweep_restart;
    logic [PERIOD_W-1:0] period_reload;
    logic [PERIOD_W-1:0] period_count;
    logic [2:0]          sequence_pos;
    logic [7:0]          length_count;
    logic                envelope_restart;
    logic [3:0]          envelope_level;
    logic [3:0]          envelope_div_count;
    logic [2:0]          sweep_div_count;
    logic                sweep_silenced;
    logic                channel_on;
  } swt_state_t;

  typedef struct packed {
    logic [3:0] level;
    logic       audible;
    logic       length_active;
  } swt_result_t;

endpackage

@@ rtl/core/swt_req_if.sv @@
interface swt_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, output req_type, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input reg_index, input write_data,
                output ready);
endinterface

@@ rtl/core/swt_res_if.sv @@
interface swt_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       audible;
  logic       length_active;

  modport source (output valid, output level, output audible, output length_active,
                  input ready);
  modport sink (input valid, input level, input audible, input length_active,
                output ready);
endinterface

@@ rtl/core/swt_cfg_if.sv @@
interface swt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/swt_update.sv @@
module swt_update (
  input  swt_pkg::swt_item_t  item,
  input  logic                negate_ones,
  input  swt_pkg::swt_state_t cur,
  output swt_pkg::swt_state_t nxt
);

  logic [swt_pkg::PERIOD_W-1:0] p;
  logic [swt_pkg::PERIOD_W-1:0] delta;
  logic [swt_pkg::PERIOD_W:0]   sub;
  logic [swt_pkg::PERIOD_W:0]   target;
  logic                         mute;

  // Sweep target and mute rule from the current period
  always_comb begin
    p     = cur.period_reload;
    delta = p >> cur.sweep_shift_amount;
    sub   = {1'b0, delta} + {{swt_pkg::PERIOD_W{1'b0}}, negate_ones};
    if (!cur.sweep_down) begin
      target = {1'b0, p} + {1'b0, delta};
    end else if (sub > {1'b0, p}) begin
      target = '0;
    end else begin
      target = {1'b0, p} - sub;
    end
    mute = target[swt_pkg::PERIOD_W] || (p < swt_pkg::MIN_PERIOD);
  end

  always_comb begin
    nxt = cur;
    case (item.req_type)
      swt_pkg::REQ_REG_WRITE: begin
        case (item.reg_index)
          swt_pkg::REG_CTRL: begin
            nxt.duty_select       = item.write_data[7:6];
            nxt.halt_or_loop      = item.write_data[5];
            nxt.fixed_volume_flag = item.write_data[4];
            nxt.volume_value      = item.write_data[3:0];
          end
          swt_pkg::REG_SWEEP: begin
            nxt.sweep_on            = item.write_data[7];
            nxt.sweep_reload_period = item.write_data[6:4];
            nxt.sweep_down          = item.write_data[3];
            nxt.sweep_shift_amount  = item.write_data[2:0];
            nxt.sweep_restart       = 1'b1;
          end
          swt_pkg::REG_PERIOD_LO: begin
            nxt.period_reload[7:0] = item.write_data;
          end
          default: begin
            nxt.period_reload[10:8] = item.write_data[2:0];
            nxt.length_count        = swt_pkg::LENGTH_LOADS[item.write_data[7:3]];
            nxt.sequence_pos        = '0;
            nxt.envelope_restart    = 1'b1;
          end
        endcase
      end
      swt_pkg::REQ_TIMER_TICK: begin
        if (cur.period_count == '0) begin
          nxt.period_count = cur.period_reload;
          nxt.sequence_pos = cur.sequence_pos - 3'd1;
        end else begin
          nxt.period_count = cur.period_count - 11'd1;
        end
      end
      swt_pkg::REQ_QUARTER: begin
        if (cur.envelope_restart) begin
          nxt.envelope_restart   = 1'b0;
          nxt.envelope_level     = swt_pkg::ENV_MAX;
          nxt.envelope_div_count = cur.volume_value;
        end else if (cur.envelope_div_count == '0) begin
          nxt.envelope_div_count = cur.volume_value;
          if (cur.envelope_level != '0) begin
            nxt.envelope_level = cur.envelope_level - 4'd1;
          end else if (cur.halt_or_loop) begin
            nxt.envelope_level = swt_pkg::ENV_MAX;
          end
        end else begin
          nxt.envelope_div_count = cur.envelope_div_count - 4'd1;
        end
      end
      swt_pkg::REQ_HALF: begin
        if (!cur.halt_or_loop && cur.length_count != '0) begin
          nxt.length_count = cur.length_count - 8'd1;
        end
        nxt.sweep_silenced = mute;
        if (cur.sweep_div_count == '0 && cur.sweep_on && cur.sweep_shift_amount != '0 &&
            !mute) begin
          nxt.period_reload = target[swt_pkg::PERIOD_W-1:0];
        end
        if (cur.sweep_div_count == '0 || cur.sweep_restart) begin
          nxt.sweep_div_count = cur.sweep_reload_period;
          nxt.sweep_restart   = 1'b0;
        end else begin
          nxt.sweep_div_count = cur.sweep_div_count - 3'd1;
        end
      end
      swt_pkg::REQ_ENABLE: begin
        if (!item.write_data[0] && cur.channel_on) begin
          nxt.length_count = '0;
        end
        nxt.channel_on = item.write_data[0];
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/swt_mix.sv @@
module swt_mix (
  input  swt_pkg::swt_state_t  st,
  output swt_pkg::swt_result_t res
);

  logic [3:0] vol;
  logic       gate;
  logic [7:0] pattern;

  always_comb begin
    vol     = st.fixed_volume_flag ? st.volume_value : st.envelope_level;
    pattern = swt_pkg::DUTY_PATTERNS[st.duty_select];
    gate    = (st.length_count != '0) && (st.period_reload >= swt_pkg::MIN_PERIOD) &&
              !st.sweep_silenced && (vol != '0);
    res.level         = (gate && pattern[st.sequence_pos]) ? vol : 4'd0;
    res.audible       = gate && st.channel_on;
    res.length_active = (st.length_count != '0);
  end

endmodule

@@ rtl/core/square_wave_tone_channel_core.sv @@
// Path: a result word follows its accepted request word through the input register,
//   then the state update and the result register.
// Throughput: one request word per cycle while res.ready holds; the state update is a
//   single pass of small adds and compares between the input and result registers.
// Reset (rst, synchronous): all channel state cleared, negate mode set to ones'
//   complement, both pipeline stages empty.
module square_wave_tone_channel_core (
  input  logic   clk,
  input  logic   rst,
  swt_req_if.sink   req,
  swt_res_if.source res,
  swt_cfg_if.sink   cfg
);

  // Input stage
  logic                 s1_valid;
  swt_pkg::swt_item_t   s1_item;
  logic                 s1_advance;

  // Channel state and configuration
  swt_pkg::swt_state_t  state;
  swt_pkg::swt_state_t  state_next;
  logic                 negate_ones;

  // Result stage
  logic                 s2_valid;
  swt_pkg::swt_result_t s2_result;
  swt_pkg::swt_result_t result_next;

  // Move the input word into the state only when the result slot is free or
  // draining this cycle; the state and the result then change on the same edge.
  assign s1_advance = s1_valid && (!s2_valid || res.ready);

  // Take a new word whenever the input register empties this cycle.
  assign req.ready = !s1_valid || s1_advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  // Payload: hold while stalled, no reset needed.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.req_type   <= req.req_type;
      s1_item.reg_index  <= req.reg_index;
      s1_item.write_data <= req.write_data;
    end
  end

  // Negate mode register; the user must write it only while the channel is idle, as the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      negate_ones <= swt_pkg::NEGATE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      negate_ones <= cfg.data;
    end
  end

  // Apply the word to the channel state.
  swt_update u_update (
    .item        (s1_item),
    .negate_ones (negate_ones),
    .cur         (state),
    .nxt         (state_next)
  );

  // Output view is taken from the state after the word is applied.
  swt_mix u_mix (
    .st  (state_next),
    .res (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_advance) begin
      s2_valid <= 1'b1;
    end else if (res.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      s2_result <= result_next;
    end
  end

  assign res.valid         = s2_valid;
  assign res.level         = s2_result.level;
  assign res.audible       = s2_result.audible;
  assign res.length_active = s2_result.length_active;

`ifndef SYNTHESIS
  // A pending result always reflects the state it was taken from.
  a_status_tracks_state: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.length_active == (state.length_count != '0)))
    else $error("length status disagrees with held state");

  // Nonzero level requires a running length counter.
  a_level_needs_length: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.level != '0) |-> res.length_active)
    else $error("nonzero level with length counter at zero");

  // Input stalls only behind a full, blocked result stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && s2_valid && !res.ready))
    else $error("input stalled without backpressure");

  // State moves only with a word.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(state))
    else $error("channel state changed with no word applied");
`endif

endmodule
